### hw/rtl/selective_repeat_reorder_buffer_macros.svh
// ---------------------------------------------------------------------------
// Selective-repeat reorder buffer: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while synchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_REORDER_BUFFER_MACROS_SVH
`define SELECTIVE_REPEAT_REORDER_BUFFER_MACROS_SVH

// Same-cycle implication
`define SRRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SRRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/srrb_pkg.sv
// ---------------------------------------------------------------------------
// srrb_pkg
// Widths, window size, slot record and control types shared by the
// reorder buffer modules.
// ---------------------------------------------------------------------------
package srrb_pkg;

  // Window size and derived index width
  localparam int WINDOW_SLOTS = 32;
  localparam int SLOT_IDX_W   = $clog2(WINDOW_SLOTS);
  localparam int SEQ_W        = 32;
  localparam int PAYLOAD_W    = 64;

  // One buffered packet
  typedef struct packed {
    logic                 valid;
    logic [PAYLOAD_W-1:0] payload;
    logic                 mark;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '0;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_DONE
  } srrb_state_t;

  // Status seen by the sequencer
  typedef struct packed {
    logic out_ready;    // output register free or emptying this cycle
    logic head_mark;    // end-of-file mark of the head cell
    logic next_valid;   // the cell behind the head holds a packet
  } srrb_status_t;

  // Controls issued by the sequencer
  typedef struct packed {
    logic                  in_stall;
    logic                  store;      // write incoming packet into a cell
    logic [SLOT_IDX_W-1:0] offset;     // cell index for a store
    logic                  shift;      // advance the window by one cell
    logic                  out_load;   // load the output register
    logic                  out_from_cell; // source is the head cell
    logic                  out_last;   // last result of this run
  } srrb_ctl_t;

endpackage

### hw/rtl/srrb_cell.sv
// ---------------------------------------------------------------------------
// srrb_cell
// One window cell. Takes its neighbour's contents on a shift, or the
// incoming packet when selected for a store.
// ---------------------------------------------------------------------------
module srrb_cell import srrb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  logic                 store,
  input  slot_t                from_next,
  input  logic [PAYLOAD_W-1:0] wr_payload,
  input  logic                 wr_mark,
  output slot_t                slot
);

  logic                 valid_r;
  logic [PAYLOAD_W-1:0] payload_r;
  logic                 mark_r;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= from_next.valid;
    end else if (store) begin
      valid_r <= 1'b1;
    end
  end

  // Packet contents, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      payload_r <= from_next.payload;
      mark_r    <= from_next.mark;
    end else if (store) begin
      payload_r <= wr_payload;
      mark_r    <= wr_mark;
    end
  end

  assign slot = '{valid: valid_r, payload: payload_r, mark: mark_r};

endmodule

### hw/rtl/srrb_ctrl.sv
// ---------------------------------------------------------------------------
// srrb_ctrl
// Sequencer: tracks the expected sequence number, classifies each arriving
// packet and steps the drain of consecutive buffered cells.
// ---------------------------------------------------------------------------
module srrb_ctrl import srrb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [SEQ_W-1:0] in_seq_number,
  input  logic             in_payload_empty,
  input  logic             in_end_of_file,
  input  srrb_status_t     status,
  output srrb_ctl_t        ctl
);

  srrb_state_t      state_r, state_nxt;
  logic [SEQ_W-1:0] expected_seq_r, expected_seq_nxt;
  logic [SEQ_W-1:0] seq_diff;
  logic             hit;
  logic             in_window;
  logic             accept;

  // Packet classification against the expected number
  assign seq_diff  = in_seq_number - expected_seq_r;
  assign hit       = (in_seq_number == expected_seq_r);
  assign in_window = (in_seq_number > expected_seq_r) &&
                     (seq_diff < SEQ_W'(WINDOW_SLOTS));
  assign accept    = in_valid && !ctl.in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && hit) begin
          if (in_end_of_file) begin
            state_nxt = ST_DONE;
          end else if (status.next_valid) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (status.out_ready) begin
          if (status.head_mark) begin
            state_nxt = ST_DONE;
          end else if (!status.next_valid) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DONE: state_nxt = ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl        = '0;
    ctl.offset = seq_diff[SLOT_IDX_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        ctl.in_stall = !status.out_ready;
        if (in_valid && status.out_ready) begin
          if (hit) begin
            ctl.out_load = 1'b1;
            ctl.out_last = in_end_of_file || !status.next_valid;
            ctl.shift    = !in_end_of_file;
          end else begin
            ctl.store = in_window && !in_payload_empty;
          end
        end
      end
      ST_DRAIN: begin
        ctl.in_stall = 1'b1;
        if (status.out_ready) begin
          ctl.out_load      = 1'b1;
          ctl.out_from_cell = 1'b1;
          ctl.out_last      = status.head_mark || !status.next_valid;
          ctl.shift         = !status.head_mark;
        end
      end
      ST_DONE: ctl.in_stall = 1'b0;   // accept and drop
      default: ctl.in_stall = 1'b1;
    endcase
  end

  // Expected number follows every window advance
  assign expected_seq_nxt = ctl.shift ? expected_seq_r + SEQ_W'(1) : expected_seq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      expected_seq_r <= '0;
    end else begin
      state_r        <= state_nxt;
      expected_seq_r <= expected_seq_nxt;
    end
  end

endmodule

### hw/rtl/selective_repeat_reorder_buffer.sv
// Selective-repeat receive window. Cell i of a row of WINDOW_SLOTS cells holds
// the packet numbered expected + i, so releasing a packet shifts the whole row
// one cell towards the head. A packet that is stale, outside the window or
// stored ahead of the head gives no result. An in-order packet is released
// first, then each consecutive buffered packet behind it is drained, the row
// moving one cell per cycle; each release waits for the output register to
// be free. The input is stalled during a drain, and any packet is held off
// while the output register holds a stalled result. After an end-of-file
// packet is released, inputs are accepted and dropped until reset.
// ---------------------------------------------------------------------------
// selective_repeat_reorder_buffer
// Top level: cell row, sequencer and output register.
// ---------------------------------------------------------------------------
`include "selective_repeat_reorder_buffer_macros.svh"

module selective_repeat_reorder_buffer import srrb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SEQ_W-1:0]     in_seq_number,
  input  logic [PAYLOAD_W-1:0] in_payload,
  input  logic                 in_payload_empty,
  input  logic                 in_end_of_file,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PAYLOAD_W-1:0] out_payload,
  output logic                 out_end_of_file,
  output logic                 out_last_of_run
);

  slot_t                cells [WINDOW_SLOTS];
  srrb_status_t         status;
  srrb_ctl_t            ctl;
  logic                 out_valid_r;
  logic [PAYLOAD_W-1:0] out_payload_r;
  logic                 out_eof_r;
  logic                 out_last_r;

  // Cell row
  for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
    slot_t from_next;
    if (i == WINDOW_SLOTS - 1) begin : g_tail
      assign from_next = SLOT_EMPTY;
    end else begin : g_mid
      assign from_next = cells[i+1];
    end
    srrb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (ctl.shift),
      .store      (ctl.store && (ctl.offset == SLOT_IDX_W'(i))),
      .from_next  (from_next),
      .wr_payload (in_payload),
      .wr_mark    (in_end_of_file),
      .slot       (cells[i])
    );
  end

  // Sequencer
  assign status.out_ready  = !out_valid_r || !out_stall;
  assign status.head_mark  = cells[0].mark;
  assign status.next_valid = cells[1].valid;

  srrb_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_seq_number    (in_seq_number),
    .in_payload_empty (in_payload_empty),
    .in_end_of_file   (in_end_of_file),
    .status           (status),
    .ctl              (ctl)
  );

  assign in_stall = ctl.in_stall;

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_payload_r <= ctl.out_from_cell ? cells[0].payload : in_payload;
      out_eof_r     <= ctl.out_from_cell ? cells[0].mark : in_end_of_file;
      out_last_r    <= ctl.out_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_payload     = out_payload_r;
  assign out_end_of_file = out_eof_r;
  assign out_last_of_run = out_last_r;

  // Checks
  `SRRB_ASSERT_IMP(a_no_shift_store, clk, rst_n, ctl.store, !ctl.shift, "store during shift")
  `SRRB_ASSERT_IMP(a_store_ahead, clk, rst_n, ctl.store, ctl.offset != '0, "store at head")
  `SRRB_ASSERT_IMP(a_drain_valid, clk, rst_n, ctl.out_load && ctl.out_from_cell, cells[0].valid, "drain of empty cell")
  `SRRB_ASSERT_IMP(a_no_overwrite, clk, rst_n, ctl.out_load, status.out_ready, "result overwritten")
  `SRRB_ASSERT_NXT(a_shift_fill, clk, rst_n, ctl.shift && cells[1].valid, cells[0].valid, "shift lost a packet")

endmodule
